// ===== hw/rtl/vqt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vqt_pkg
// Shared sizes, field widths, request modes and status codes for the value
// queue table.
// ----------------------------------------------------------------------------
package vqt_pkg;

  localparam int DEPTH   = 16;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);

  localparam int MODE_W  = 3;
  localparam int VALUE_W = 32;
  localparam int STAT_W  = 2;
  localparam int HITS_W  = 5;

  localparam logic [HITS_W-1:0] HITS_MAX = '1;

  localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MODIFY = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DELETE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_VIEW   = 3'd4;

  localparam logic [STAT_W-1:0] STAT_DONE      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd3;

endpackage

// ===== hw/rtl/value_queue_table_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// value_queue_table_core
// Ordered list of 32-bit values with insert, search, modify, delete and view
// requests, walked one entry per cycle (view stalls on output), 1R1W table.
// ----------------------------------------------------------------------------
// Flow: insert, bad mode or empty list go straight to the response state;
//   search, modify and delete scan the list first, and the delete shift
//   takes over from the scan once the match is found.
// Requests: one at a time; view delivers one entry per cycle unless the
//   output stalls, a pace set by the walk over the table's single read port.
// Reset: rst clears the entry count and the output valid; table contents
//   stay undefined until written.
module value_queue_table_core
  import vqt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [31:0] key_value, [63:32] new_value
  input  logic [2:0]  s_tuser,   // [2:0] mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [1:0] status, [33:2] entry_value,
                                 // [38:34] match_count, rest zero
  output logic        m_tlast    // last result of the request
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_VIEW,
    S_RESP
  } state_t;

  state_t              state;
  logic [CNT_W-1:0]    count;
  logic [IDX_W-1:0]    idx;
  logic [HITS_W-1:0]   hits;
  logic [MODE_W-1:0]   mode_r;
  logic [VALUE_W-1:0]  key_r;
  logic [VALUE_W-1:0]  newv_r;
  logic [STAT_W-1:0]   res_status;
  logic [HITS_W-1:0]   res_hits;

  logic [STAT_W-1:0]   out_status;
  logic [VALUE_W-1:0]  out_value;
  logic [HITS_W-1:0]   out_hits;

  logic [VALUE_W-1:0]  mem [DEPTH];
  logic [VALUE_W-1:0]  rd_data;

  logic                accept;
  logic                out_free;
  logic                load_out;
  logic                is_last;
  logic                hit;
  logic [HITS_W-1:0]   hits_next;
  logic                mem_we;
  logic                mem_re;
  logic [IDX_W-1:0]    mem_waddr;
  logic [IDX_W-1:0]    mem_raddr;
  logic [VALUE_W-1:0]  mem_wdata;

  logic [MODE_W-1:0]   in_mode;
  logic [VALUE_W-1:0]  in_key;
  logic [VALUE_W-1:0]  in_newv;

  assign in_mode = s_tuser;
  assign in_key  = s_tdata[31:0];
  assign in_newv = s_tdata[63:32];

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign load_out = out_free && ((state == S_VIEW) || (state == S_RESP));
  assign is_last  = ((CNT_W'(idx) + CNT_W'(1)) == count);
  assign hit      = (rd_data == key_r);
  assign hits_next = (hit && (hits != HITS_MAX)) ? hits + HITS_W'(1) : hits;

  assign m_tdata = {1'b0, out_hits, out_value, out_status};

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = idx;
    mem_raddr = idx + IDX_W'(1);
    mem_wdata = key_r;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_mode == MODE_INSERT) begin
            if (count != CNT_W'(DEPTH)) begin
              mem_we    = 1'b1;
              mem_waddr = count[IDX_W-1:0];
              mem_wdata = in_key;
            end
          end else if ((in_mode <= MODE_VIEW) && (count != '0)) begin
            mem_re    = 1'b1;
            mem_raddr = '0;
          end
        end
      end
      S_SCAN: begin
        if ((mode_r == MODE_MODIFY) && hit) begin
          mem_we    = 1'b1;
          mem_wdata = newv_r;
        end else if (!is_last) begin
          mem_re = 1'b1;
        end
      end
      S_SHIFT: begin
        // move the current entry one place toward the head
        mem_we    = 1'b1;
        mem_waddr = idx - IDX_W'(1);
        mem_wdata = rd_data;
        mem_re    = !is_last;
      end
      S_VIEW: begin
        mem_re = out_free && !is_last;
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            mode_r   <= in_mode;
            key_r    <= in_key;
            newv_r   <= in_newv;
            idx      <= '0;
            hits     <= '0;
            res_hits <= '0;
            if (in_mode == MODE_INSERT) begin
              if (count == CNT_W'(DEPTH)) begin
                res_status <= STAT_FULL;
              end else begin
                res_status <= STAT_DONE;
                count      <= count + CNT_W'(1);
              end
              state <= S_RESP;
            end else if (in_mode > MODE_VIEW) begin
              res_status <= STAT_NOT_FOUND;
              state      <= S_RESP;
            end else if (count == '0) begin
              res_status <= STAT_EMPTY;
              state      <= S_RESP;
            end else if (in_mode == MODE_VIEW) begin
              state <= S_VIEW;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          case (mode_r)
            MODE_SEARCH: begin
              if (is_last) begin
                res_status <= (hits_next != '0) ? STAT_DONE : STAT_NOT_FOUND;
                res_hits   <= hits_next;
                state      <= S_RESP;
              end else begin
                hits <= hits_next;
                idx  <= idx + IDX_W'(1);
              end
            end
            MODE_MODIFY: begin
              if (hit) begin
                res_status <= STAT_DONE;
                state      <= S_RESP;
              end else if (is_last) begin
                res_status <= STAT_NOT_FOUND;
                state      <= S_RESP;
              end else begin
                idx <= idx + IDX_W'(1);
              end
            end
            MODE_DELETE: begin
              if (hit && is_last) begin
                count      <= count - CNT_W'(1);
                res_status <= STAT_DONE;
                state      <= S_RESP;
              end else if (hit) begin
                idx   <= idx + IDX_W'(1);
                state <= S_SHIFT;
              end else if (is_last) begin
                res_status <= STAT_NOT_FOUND;
                state      <= S_RESP;
              end else begin
                idx <= idx + IDX_W'(1);
              end
            end
            default: begin
              res_status <= STAT_NOT_FOUND;
              state      <= S_RESP;
            end
          endcase
        end
        S_SHIFT: begin
          if (is_last) begin
            count      <= count - CNT_W'(1);
            res_status <= STAT_DONE;
            state      <= S_RESP;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        S_VIEW: begin
          // hold the walk while the previous entry waits at the output
          if (out_free) begin
            out_status <= STAT_DONE;
            out_value  <= rd_data;
            out_hits   <= '0;
            m_tlast    <= is_last;
            if (is_last) begin
              state <= S_IDLE;
            end else begin
              idx <= idx + IDX_W'(1);
            end
          end
        end
        S_RESP: begin
          if (out_free) begin
            out_status <= res_status;
            out_value  <= '0;
            out_hits   <= res_hits;
            m_tlast    <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
